>>> design/iss_pkg.sv
// shared types and constants of the interval shutter sequencer
package iss_pkg;

  // field and register widths
  localparam int unsigned TICKS_W    = 22;
  localparam int unsigned SECS_W     = 12;
  localparam int unsigned FOCUS_W    = 13;
  localparam int unsigned SHUTTER_W  = 11;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // phase counter saturation point
  localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

  // register reset values
  localparam logic [SECS_W-1:0]    INTERVAL_RST = SECS_W'(10);
  localparam logic [FOCUS_W-1:0]   FOCUS_RST    = FOCUS_W'(500);
  localparam logic [SHUTTER_W-1:0] SHUTTER_RST  = SHUTTER_W'(200);

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL_SEC    = 3'd0,
    REG_FOCUS_TIME_MS   = 3'd1,
    REG_SHUTTER_TIME_MS = 3'd2,
    REG_FOCUS_ENABLE    = 3'd3,
    REG_PRE_FOCUS       = 3'd4,
    REG_ACTIVE_HIGH     = 3'd5,
    REG_SWAP_LINES      = 3'd6
  } reg_idx_t;

  // sequencer phases, one-hot
  typedef enum logic [3:0] {
    PH_DISARMED = 4'b0001,
    PH_ARMED    = 4'b0010,
    PH_FOCUSING = 4'b0100,
    PH_SHOOTING = 4'b1000
  } phase_t;

  // phase codes as shown on the result channel
  localparam logic [PHASE_W-1:0] CODE_DISARMED = 2'd0;
  localparam logic [PHASE_W-1:0] CODE_ARMED    = 2'd1;
  localparam logic [PHASE_W-1:0] CODE_FOCUSING = 2'd2;
  localparam logic [PHASE_W-1:0] CODE_SHOOTING = 2'd3;

  // settings handed from the register bank to the sequencer
  typedef struct packed {
    logic [SECS_W-1:0]    interval_sec;
    logic [TICKS_W-1:0]   interval_ticks;
    logic [FOCUS_W-1:0]   focus_time_ms;
    logic [SHUTTER_W-1:0] shutter_time_ms;
    logic                 focus_enable;
    logic                 pre_focus;
    logic                 active_high;
    logic                 swap_lines;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic               line_a_level;
    logic               line_b_level;
    logic [PHASE_W-1:0] phase;
    logic [SECS_W-1:0]  seconds_left;
  } result_t;

endpackage

>>> design/iss_in_if.sv
// input channel: tick and press events
interface iss_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic press;

  modport source (output valid, output tick, output press, input ready);
  modport sink   (input valid, input tick, input press, output ready);
endinterface

>>> design/iss_out_if.sv
// result channel: line levels, phase and seconds left
interface iss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          line_a_level;
  logic                          line_b_level;
  logic [iss_pkg::PHASE_W-1:0]   phase;
  logic [iss_pkg::SECS_W-1:0]    seconds_left;

  modport source (output valid, output line_a_level, output line_b_level,
                  output phase, output seconds_left, input ready);
  modport sink   (input valid, input line_a_level, input line_b_level,
                  input phase, input seconds_left, output ready);
endinterface

>>> design/iss_cfg_regs.sv
// configuration register bank with the interval kept in ticks
module iss_cfg_regs #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [iss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output iss_pkg::cfg_t                    cfg
);

  localparam logic [iss_pkg::TICKS_W-1:0] TPS_TICKS = iss_pkg::TICKS_W'(TICKS_PER_SECOND);

  logic [iss_pkg::TICKS_W-1:0] wdata_ticks;

  // interval converted at write time so it is ready with the seconds value
  assign wdata_ticks = iss_pkg::TICKS_W'(
      {{(iss_pkg::TICKS_W-iss_pkg::SECS_W){1'b0}}, cfg_wdata[iss_pkg::SECS_W-1:0]} * TPS_TICKS);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_sec    <= iss_pkg::INTERVAL_RST;
      cfg.interval_ticks  <= iss_pkg::TICKS_W'(
          {{(iss_pkg::TICKS_W-iss_pkg::SECS_W){1'b0}}, iss_pkg::INTERVAL_RST} * TPS_TICKS);
      cfg.focus_time_ms   <= iss_pkg::FOCUS_RST;
      cfg.shutter_time_ms <= iss_pkg::SHUTTER_RST;
      cfg.focus_enable    <= 1'b1;
      cfg.pre_focus       <= 1'b1;
      cfg.active_high     <= 1'b0;
      cfg.swap_lines      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        iss_pkg::REG_INTERVAL_SEC: begin
          cfg.interval_sec   <= cfg_wdata[iss_pkg::SECS_W-1:0];
          cfg.interval_ticks <= wdata_ticks;
        end
        iss_pkg::REG_FOCUS_TIME_MS:   cfg.focus_time_ms   <= cfg_wdata[iss_pkg::FOCUS_W-1:0];
        iss_pkg::REG_SHUTTER_TIME_MS: cfg.shutter_time_ms <= cfg_wdata[iss_pkg::SHUTTER_W-1:0];
        iss_pkg::REG_FOCUS_ENABLE:    cfg.focus_enable    <= cfg_wdata[0];
        iss_pkg::REG_PRE_FOCUS:       cfg.pre_focus       <= cfg_wdata[0];
        iss_pkg::REG_ACTIVE_HIGH:     cfg.active_high     <= cfg_wdata[0];
        iss_pkg::REG_SWAP_LINES:      cfg.swap_lines      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/iss_seq_core.sv
// phase state, tick counters and the per-transaction next-state and result logic
module iss_seq_core #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic             clk,
  input  logic             rst,
  input  iss_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic             tick,
  input  logic             press,
  output iss_pkg::result_t result
);

  localparam int unsigned SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

  iss_pkg::phase_t              phase, phase_mid, phase_next;
  logic [iss_pkg::TICKS_W-1:0]  ticks, ticks_inc, ticks_mid, ticks_next;
  logic [SUB_W-1:0]             sub, sub_inc, sub_next;
  // whole seconds elapsed since phase entry
  logic [iss_pkg::SECS_W-1:0]   secs, secs_inc, secs_next;
  logic                         focus_held, focus_mid, focus_held_next;
  logic                         entered;
  logic [iss_pkg::TICKS_W-1:0]  fire_at;
  logic [iss_pkg::TICKS_W-1:0]  focus_ticks, shutter_ticks;
  logic                         lvl_focus, lvl_shutter;

  assign focus_ticks   = {{(iss_pkg::TICKS_W-iss_pkg::FOCUS_W){1'b0}}, cfg.focus_time_ms};
  assign shutter_ticks = {{(iss_pkg::TICKS_W-iss_pkg::SHUTTER_W){1'b0}}, cfg.shutter_time_ms};

  // tick advance: saturating phase counter, split into sub-second and whole-second parts
  always_comb begin
    ticks_inc = ticks;
    sub_inc   = sub;
    secs_inc  = secs;
    if (tick && (ticks != iss_pkg::TICKS_MAX)) begin
      ticks_inc = ticks + iss_pkg::TICKS_W'(1);
      if (sub == SUB_LAST) begin
        sub_inc  = '0;
        secs_inc = secs + iss_pkg::SECS_W'(1);
      end else begin
        sub_inc = sub + SUB_W'(1);
      end
    end
  end

  // press arms from disarmed and disarms from any other phase
  always_comb begin
    phase_mid = phase;
    ticks_mid = ticks_inc;
    focus_mid = focus_held;
    if (press) begin
      phase_mid = (phase == iss_pkg::PH_DISARMED) ? iss_pkg::PH_ARMED : iss_pkg::PH_DISARMED;
      ticks_mid = '0;
      focus_mid = 1'b0;
    end
  end

  // firing threshold, early by the focus time when pre-focus applies
  always_comb begin
    fire_at = cfg.interval_ticks;
    if (cfg.focus_enable && cfg.pre_focus && (focus_ticks < cfg.interval_ticks)) begin
      fire_at = cfg.interval_ticks - focus_ticks;
    end
  end

  // at most one timed transition after the press
  always_comb begin
    phase_next      = phase_mid;
    focus_held_next = focus_mid;
    entered         = press;
    case (phase_mid)
      iss_pkg::PH_ARMED: begin
        if (ticks_mid >= fire_at) begin
          entered = 1'b1;
          if (cfg.focus_enable) begin
            phase_next      = iss_pkg::PH_FOCUSING;
            focus_held_next = 1'b1;
          end else begin
            phase_next = iss_pkg::PH_SHOOTING;
          end
        end
      end
      iss_pkg::PH_FOCUSING: begin
        if (ticks_mid >= focus_ticks) begin
          entered    = 1'b1;
          phase_next = iss_pkg::PH_SHOOTING;
        end
      end
      iss_pkg::PH_SHOOTING: begin
        if (ticks_mid >= shutter_ticks) begin
          entered         = 1'b1;
          phase_next      = iss_pkg::PH_ARMED;
          focus_held_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // counters restart on any phase entry
  always_comb begin
    if (entered) begin
      ticks_next = '0;
      sub_next   = '0;
      secs_next  = '0;
    end else begin
      ticks_next = ticks_inc;
      sub_next   = sub_inc;
      secs_next  = secs_inc;
    end
  end

  // result fields from the state after this transaction
  always_comb begin
    lvl_focus   = focus_held_next ? cfg.active_high : ~cfg.active_high;
    lvl_shutter = (phase_next == iss_pkg::PH_SHOOTING) ? cfg.active_high : ~cfg.active_high;
    result.line_a_level = cfg.swap_lines ? lvl_shutter : lvl_focus;
    result.line_b_level = cfg.swap_lines ? lvl_focus : lvl_shutter;
    case (phase_next)
      iss_pkg::PH_DISARMED: result.phase = iss_pkg::CODE_DISARMED;
      iss_pkg::PH_ARMED:    result.phase = iss_pkg::CODE_ARMED;
      iss_pkg::PH_FOCUSING: result.phase = iss_pkg::CODE_FOCUSING;
      iss_pkg::PH_SHOOTING: result.phase = iss_pkg::CODE_SHOOTING;
      default:              result.phase = iss_pkg::CODE_DISARMED;
    endcase
    // seconds left rounded up is the interval less the whole seconds elapsed
    if ((phase_next == iss_pkg::PH_ARMED) && (ticks_next < cfg.interval_ticks)) begin
      result.seconds_left = cfg.interval_sec - secs_next;
    end else begin
      result.seconds_left = '0;
    end
  end

  // state update once per processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= iss_pkg::PH_DISARMED;
      ticks      <= '0;
      sub        <= '0;
      secs       <= '0;
      focus_held <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      ticks      <= ticks_next;
      sub        <= sub_next;
      secs       <= secs_next;
      focus_held <= focus_held_next;
    end
  end

endmodule

>>> design/interval_shutter_sequencer.sv
// interval shutter sequencer: an input transaction passes the input register, then the
// result register; one transaction per cycle sustained while the result side is ready,
// with the next-state logic combinational between the two registers
// synchronous active-high reset returns the block to disarmed with a zero counter
// and all settings at their defaults; no clearing pass is needed
module interval_shutter_sequencer #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                             clk,
  input  logic                             rst,
  iss_in_if.sink                           in_ch,
  iss_out_if.source                        out_ch,
  input  logic                             cfg_wr_en,
  input  logic [iss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  iss_pkg::cfg_t    cfg;
  iss_pkg::result_t result;
  iss_pkg::result_t out_data;

  logic in_full;
  logic in_tick;
  logic in_press;
  logic out_valid;
  logic advance;
  logic accept;

  // settings
  iss_cfg_regs #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline handshake: the held item moves on when the result slot is free or draining
  assign advance     = in_full && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_full || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_tick  <= in_ch.tick;
      in_press <= in_ch.press;
    end
  end

  // sequencer
  iss_seq_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .tick   (in_tick),
    .press  (in_press),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.line_a_level = out_data.line_a_level;
  assign out_ch.line_b_level = out_data.line_b_level;
  assign out_ch.phase        = out_data.phase;
  assign out_ch.seconds_left = out_data.seconds_left;

endmodule

>>> bench/iss_shot_checker.sv
// result checker for the interval shutter sequencer: own prediction, in-order comparison
module iss_shot_checker #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                           clk,
  input  logic                           rst,
  iss_in_if                              shot_in,
  iss_out_if                             shot_out,
  input  logic                           cfg_wr_en,
  input  logic [iss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_due
);

  localparam int unsigned REPORT_LIMIT = 10;

  // own copy of the settings
  logic [iss_pkg::SECS_W-1:0]    interval_sec;
  logic [iss_pkg::FOCUS_W-1:0]   focus_time;
  logic [iss_pkg::SHUTTER_W-1:0] shutter_time;
  logic                          focus_enable;
  logic                          pre_focus;
  logic                          active_high;
  logic                          swap_lines;

  // own copy of the sequencer state
  iss_pkg::phase_t               phase_now;
  logic [iss_pkg::TICKS_W-1:0]   phase_ticks;
  logic                          focus_held;

  iss_pkg::result_t              line_results_due[$];
  iss_pkg::result_t              due_result;
  iss_pkg::result_t              seen_result;
  int unsigned                   mismatches = 0;
  string                         due_text;
  string                         seen_text;

  // phase entry restarts the counter; focus stays held from focusing into shooting
  function automatic void enter_phase(input iss_pkg::phase_t next_phase);
    phase_now   = next_phase;
    phase_ticks = '0;
    if (next_phase == iss_pkg::PH_FOCUSING) begin
      focus_held = 1'b1;
    end else if (next_phase != iss_pkg::PH_SHOOTING) begin
      focus_held = 1'b0;
    end
  endfunction

  // one input transaction: tick, then press, then at most one timed transition
  function automatic iss_pkg::result_t sequence_step(input logic tick, input logic press);
    logic [31:0]      interval_ticks;
    logic [31:0]      fire_at;
    logic [31:0]      secs;
    logic             focus_level;
    logic             shutter_level;
    iss_pkg::result_t r;
    interval_ticks = 32'(interval_sec) * TICKS_PER_SECOND;
    if (tick && phase_ticks != iss_pkg::TICKS_MAX) begin
      phase_ticks = phase_ticks + 1'b1;
    end
    if (press) begin
      enter_phase(phase_now == iss_pkg::PH_DISARMED ? iss_pkg::PH_ARMED : iss_pkg::PH_DISARMED);
    end
    case (phase_now)
      iss_pkg::PH_ARMED: begin
        fire_at = interval_ticks;
        // early start so that the shutter lands on the interval
        if (focus_enable && pre_focus && 32'(focus_time) < interval_ticks) begin
          fire_at = interval_ticks - 32'(focus_time);
        end
        if (32'(phase_ticks) >= fire_at) begin
          enter_phase(focus_enable ? iss_pkg::PH_FOCUSING : iss_pkg::PH_SHOOTING);
        end
      end
      iss_pkg::PH_FOCUSING: begin
        if (phase_ticks >= iss_pkg::TICKS_W'(focus_time)) begin
          enter_phase(iss_pkg::PH_SHOOTING);
        end
      end
      iss_pkg::PH_SHOOTING: begin
        if (phase_ticks >= iss_pkg::TICKS_W'(shutter_time)) begin
          enter_phase(iss_pkg::PH_ARMED);
        end
      end
      default: begin
      end
    endcase
    // whole seconds left, rounded up, only while armed
    secs = '0;
    if (phase_now == iss_pkg::PH_ARMED && 32'(phase_ticks) < interval_ticks) begin
      secs = (interval_ticks - 32'(phase_ticks) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
    end
    focus_level    = focus_held ? active_high : ~active_high;
    shutter_level  = (phase_now == iss_pkg::PH_SHOOTING) ? active_high : ~active_high;
    r.line_a_level = swap_lines ? shutter_level : focus_level;
    r.line_b_level = swap_lines ? focus_level : shutter_level;
    case (phase_now)
      iss_pkg::PH_ARMED:    r.phase = iss_pkg::CODE_ARMED;
      iss_pkg::PH_FOCUSING: r.phase = iss_pkg::CODE_FOCUSING;
      iss_pkg::PH_SHOOTING: r.phase = iss_pkg::CODE_SHOOTING;
      default:              r.phase = iss_pkg::CODE_DISARMED;
    endcase
    r.seconds_left = secs[iss_pkg::SECS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      interval_sec  = iss_pkg::INTERVAL_RST;
      focus_time    = iss_pkg::FOCUS_RST;
      shutter_time  = iss_pkg::SHUTTER_RST;
      focus_enable  = 1'b1;
      pre_focus     = 1'b1;
      active_high   = 1'b0;
      swap_lines    = 1'b0;
      phase_now     = iss_pkg::PH_DISARMED;
      phase_ticks   = '0;
      focus_held    = 1'b0;
      line_results_due.delete();
    end else begin
      // register writes, masked to each register's width
      if (cfg_wr_en) begin
        case (cfg_index)
          iss_pkg::REG_INTERVAL_SEC:    interval_sec = cfg_wdata[iss_pkg::SECS_W-1:0];
          iss_pkg::REG_FOCUS_TIME_MS:   focus_time   = cfg_wdata[iss_pkg::FOCUS_W-1:0];
          iss_pkg::REG_SHUTTER_TIME_MS: shutter_time = cfg_wdata[iss_pkg::SHUTTER_W-1:0];
          iss_pkg::REG_FOCUS_ENABLE:    focus_enable = cfg_wdata[0];
          iss_pkg::REG_PRE_FOCUS:       pre_focus    = cfg_wdata[0];
          iss_pkg::REG_ACTIVE_HIGH:     active_high  = cfg_wdata[0];
          iss_pkg::REG_SWAP_LINES:      swap_lines   = cfg_wdata[0];
          default: begin
          end
        endcase
      end

      // result transaction against the oldest expectation
      if (shot_out.valid && shot_out.ready) begin
        seen_result.line_a_level = shot_out.line_a_level;
        seen_result.line_b_level = shot_out.line_b_level;
        seen_result.phase        = shot_out.phase;
        seen_result.seconds_left = shot_out.seconds_left;
        seen_text = $sformatf("a=%0b b=%0b phase=%0d secs=%0d",
                              seen_result.line_a_level, seen_result.line_b_level,
                              seen_result.phase, seen_result.seconds_left);
        if (line_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result transaction: %s", seen_text);
          end
        end else begin
          due_result = line_results_due.pop_front();
          if (seen_result.line_a_level !== due_result.line_a_level ||
              seen_result.line_b_level !== due_result.line_b_level ||
              seen_result.phase        !== due_result.phase ||
              seen_result.seconds_left !== due_result.seconds_left) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              due_text = $sformatf("a=%0b b=%0b phase=%0d secs=%0d",
                                   due_result.line_a_level, due_result.line_b_level,
                                   due_result.phase, due_result.seconds_left);
              $display("result mismatch: expected %s, got %s", due_text, seen_text);
            end
          end
        end
      end

      // input transaction: work out its result
      if (shot_in.valid && shot_in.ready) begin
        line_results_due.push_back(sequence_step(shot_in.tick, shot_in.press));
      end
    end
    results_due    <= line_results_due.size();
    mismatch_count <= mismatches;
  end

endmodule

>>> bench/tb_interval_shutter_sequencer.sv
// testbench top: clock, reset, stimulus and verdict for the interval shutter sequencer
module tb_interval_shutter_sequencer;

  localparam int unsigned TICKS_PER_SEC   = 1000;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam logic [iss_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // settings styles for the random part
  typedef enum int unsigned {
    STYLE_FAST_CYCLE,
    STYLE_FAST_REPEAT,
    STYLE_EARLY_FOCUS,
    STYLE_ANY_VALUE
  } settings_style_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [iss_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [iss_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int unsigned                    mismatch_count;
  int unsigned                    results_due;
  int unsigned                    cycle_count;
  int unsigned                    out_stall;
  logic                           in_burst;
  logic                           out_burst;
  settings_style_t                style;

  iss_in_if  shot_in ();
  iss_out_if shot_out ();

  interval_shutter_sequencer #(
    .TICKS_PER_SECOND(TICKS_PER_SEC)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (shot_in),
    .out_ch    (shot_out),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  iss_shot_checker #(
    .TICKS_PER_SECOND(TICKS_PER_SEC)
  ) shot_checker (
    .clk            (clk),
    .rst            (rst),
    .shot_in        (shot_in),
    .shot_out       (shot_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stall before each transaction, with bursts of none
  initial begin
    shot_out.ready <= 1'b0;
    out_burst = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 49) == 0) begin
        out_burst = ~out_burst;
      end
      out_stall = out_burst ? 0 : $urandom_range(0, 10);
      if (out_stall != 0) begin
        shot_out.ready <= 1'b0;
        repeat (out_stall) @(posedge clk);
      end
      shot_out.ready <= 1'b1;
      do @(posedge clk); while (!shot_out.valid);
    end
  end

  // one input transaction after a random gap
  task automatic send_item(input logic tick, input logic press);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) begin
      in_burst = ~in_burst;
    end
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      shot_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    shot_in.valid <= 1'b1;
    shot_in.tick  <= tick;
    shot_in.press <= press;
    do @(posedge clk); while (!shot_in.ready);
  endtask

  // stop sending and wait until every result has come back
  task automatic settle();
    shot_in.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_reg(input logic [iss_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= iss_pkg::CFG_DATA_W'(data);
    @(posedge clk);
  endtask

  // full register set, optionally with a write to the unused index
  task automatic write_settings(input int unsigned interval_sec, input int unsigned focus_ms,
                                input int unsigned shutter_ms, input int unsigned focus_on,
                                input int unsigned early_focus, input int unsigned high_active,
                                input int unsigned swapped, input logic spare);
    write_reg(iss_pkg::REG_INTERVAL_SEC, interval_sec);
    write_reg(iss_pkg::REG_FOCUS_TIME_MS, focus_ms);
    write_reg(iss_pkg::REG_SHUTTER_TIME_MS, shutter_ms);
    write_reg(iss_pkg::REG_FOCUS_ENABLE, focus_on);
    write_reg(iss_pkg::REG_PRE_FOCUS, early_focus);
    write_reg(iss_pkg::REG_ACTIVE_HIGH, high_active);
    write_reg(iss_pkg::REG_SWAP_LINES, swapped);
    if (spare) begin
      write_reg(REG_SPARE, $urandom);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // stimulus
  initial begin
    shot_in.valid <= 1'b0;
    shot_in.tick  <= 1'b0;
    shot_in.press <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= iss_pkg::REG_INTERVAL_SEC;
    cfg_wdata     <= '0;
    in_burst = 1'b0;
    do @(posedge clk); while (rst);

    // defaults: idle ticks, arm, count down, press together with a tick
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b1);
    settle();

    // zero interval and zero hold times, lines active high and swapped
    write_settings(0, 0, 0, 1, 1, 1, 1, 1'b1);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    settle();

    // all-ones data masked to each width; flags written with bit zero clear
    write_settings('h1FFF, 'h1FFF, 'h1FFF, 'h1FFE, 'h1FFE, 'h1FFE, 'h1FFE, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    settle();

    // large in-range settings with pre-focus
    write_settings(3600, 5000, 2000, 1, 1, 0, 0, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    settle();

    // direct shot: focus disabled, shutter line alone
    write_settings(0, 0, 2, 0, 1, 1, 0, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    settle();

    // random part: mostly short timings so that whole shot cycles complete
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      style = settings_style_t'($urandom_range(0, 3));
      case (style)
        STYLE_FAST_CYCLE, STYLE_FAST_REPEAT: begin
          write_settings(0, $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom, $urandom, 1'($urandom));
        end
        STYLE_EARLY_FOCUS: begin
          write_settings(1, $urandom_range(985, 999), $urandom_range(0, 6), 1, 1,
                         $urandom, $urandom, 1'($urandom));
        end
        default: begin
          write_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, 1'($urandom));
        end
      endcase
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item($urandom_range(0, 9) != 0, $urandom_range(0, 24) == 0);
      end
      settle();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
design/iss_pkg.sv
design/iss_in_if.sv
design/iss_out_if.sv
design/iss_cfg_regs.sv
design/iss_seq_core.sv
design/interval_shutter_sequencer.sv
bench/iss_shot_checker.sv
bench/tb_interval_shutter_sequencer.sv
